// ===== src/ctsup_pkg.sv =====
// Shared codes for the contactor supervisor: node states, request types, register indexes.
`default_nettype none
package ctsup_pkg;

	localparam int StateW = 3;
	localparam int ReqW   = 2;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;
	localparam int TimeW  = 32;

	typedef logic [StateW-1:0]   node_state_t;
	typedef logic [ReqW-1:0]     req_t;
	typedef logic [CfgIdxW-1:0]  cfg_idx_t;
	typedef logic [CfgDataW-1:0] timeout_t;
	typedef logic [TimeW-1:0]    time_t;

	localparam node_state_t ST_OFF          = 3'd0;
	localparam node_state_t ST_STARTING     = 3'd1;
	localparam node_state_t ST_ON           = 3'd2;
	localparam node_state_t ST_STOPPING     = 3'd3;
	localparam node_state_t ST_ERR_IDLE     = 3'd4;
	localparam node_state_t ST_ERR_START    = 3'd5;
	localparam node_state_t ST_ERR_STOPDONE = 3'd6;
	localparam node_state_t ST_ERR_STOPHOLD = 3'd7;

	localparam req_t REQ_CHECK     = 2'd0;
	localparam req_t REQ_TURN_ON   = 2'd1;
	localparam req_t REQ_TURN_OFF  = 2'd2;
	localparam req_t REQ_ALARM_OFF = 2'd3;

	localparam cfg_idx_t CFG_IS_CONTACTOR  = 2'd0;
	localparam cfg_idx_t CFG_INVERSE_LOGIC = 2'd1;
	localparam cfg_idx_t CFG_ON_TIMEOUT    = 2'd2;
	localparam cfg_idx_t CFG_OFF_TIMEOUT   = 2'd3;

	localparam timeout_t TIMEOUT_RESET = 16'd1000;

endpackage
`default_nettype wire

// ===== src/contactor_supervisor.sv =====
// Contactor supervisor top level: node state machine, drive latch, timeout timer.
// The result is registered at the edge that accepts the request.
// Throughput: one request per cycle while in_stall is low; the node state update is a
// single pass of logic (one 32-bit subtract and compare) into the state and result registers.
// The result register decouples the sides: a new request is taken whenever the
// result register is empty or being taken in the same cycle.
// Reset (arst_n low, asynchronous): state off, drive 0, timer cleared, config registers at defaults.
`default_nettype none
module contactor_supervisor
	import ctsup_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire cfg_idx_t    cfg_index,
	input  wire timeout_t    cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire req_t        req_type,
	input  wire logic        feedback_level,
	input  wire time_t       time_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output node_state_t      old_state,
	output node_state_t      new_state,
	output logic             input_on,
	output logic             drive_level
);

	logic        is_contactor_q;
	logic        inverse_logic_q;
	timeout_t    on_timeout_q;
	timeout_t    off_timeout_q;

	node_state_t state_q;
	logic        drive_q;
	logic        timer_started_q;
	time_t       start_time_q;
	logic        last_input_q;

	node_state_t old_state_q;
	node_state_t new_state_q;
	logic        input_on_q;
	logic        drive_level_q;
	logic        out_valid_q;

	node_state_t nx_state;
	logic        nx_drive;
	logic        nx_timer_started;
	time_t       nx_start_time;
	logic        nx_last_input;
	logic        in_on;
	time_t       elapsed;
	logic        on_expired;
	logic        off_expired;
	logic        in_accept;

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	assign in_on       = feedback_level ^ inverse_logic_q;
	assign elapsed     = time_ms - start_time_q;
	assign on_expired  = elapsed > {{(TimeW-CfgDataW){1'b0}}, on_timeout_q};
	assign off_expired = elapsed > {{(TimeW-CfgDataW){1'b0}}, off_timeout_q};

	always_comb begin
		nx_state         = state_q;
		nx_drive         = drive_q;
		nx_timer_started = timer_started_q;
		nx_start_time    = start_time_q;
		nx_last_input    = last_input_q;
		if (req_type == REQ_CHECK) begin
			nx_last_input = in_on;
			if (!is_contactor_q) begin
				nx_state = in_on ? ST_ON : ST_OFF;
			end else begin
				case (state_q)
					ST_OFF: begin
						if (drive_q || in_on)
							nx_state = ST_ERR_IDLE;
					end
					ST_STARTING: begin
						if (!timer_started_q) begin
							nx_drive         = 1'b1;
							nx_timer_started = 1'b1;
							nx_start_time    = time_ms;
						end else if (on_expired) begin
							nx_state = ST_ON;
						end
						if (!(nx_drive && in_on))
							nx_state = ST_ERR_START;
					end
					ST_STOPPING: begin
						if (!timer_started_q) begin
							nx_timer_started = 1'b1;
							nx_start_time    = time_ms;
						end else if (off_expired) begin
							nx_drive = 1'b0;
							nx_state = ST_OFF;
						end
						if (nx_state == ST_OFF) begin
							if (nx_drive || in_on)
								nx_state = ST_ERR_STOPDONE;
						end else if (!(nx_drive && in_on)) begin
							nx_state = ST_ERR_STOPHOLD;
						end
					end
					default: ;
				endcase
			end
		end else if (is_contactor_q) begin
			case (req_type)
				REQ_TURN_ON: begin
					nx_timer_started = 1'b0;
					nx_state         = ST_STARTING;
				end
				REQ_TURN_OFF: begin
					nx_timer_started = 1'b0;
					nx_state         = ST_STOPPING;
				end
				default: begin
					nx_drive = 1'b0;
					nx_state = ST_OFF;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_contactor_q  <= 1'b1;
			inverse_logic_q <= 1'b0;
			on_timeout_q    <= TIMEOUT_RESET;
			off_timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IS_CONTACTOR:  is_contactor_q  <= cfg_data[0];
				CFG_INVERSE_LOGIC: inverse_logic_q <= cfg_data[0];
				CFG_ON_TIMEOUT:    on_timeout_q    <= cfg_data;
				CFG_OFF_TIMEOUT:   off_timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_OFF;
			drive_q         <= 1'b0;
			timer_started_q <= 1'b0;
			start_time_q    <= '0;
			last_input_q    <= 1'b0;
		end else if (in_accept) begin
			state_q         <= nx_state;
			drive_q         <= nx_drive;
			timer_started_q <= nx_timer_started;
			start_time_q    <= nx_start_time;
			last_input_q    <= nx_last_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, held while the request waits downstream
	always_ff @(posedge clk) begin
		if (in_accept) begin
			old_state_q   <= state_q;
			new_state_q   <= nx_state;
			input_on_q    <= nx_last_input;
			drive_level_q <= nx_drive;
		end
	end

	assign out_valid   = out_valid_q;
	assign old_state   = old_state_q;
	assign new_state   = new_state_q;
	assign input_on    = input_on_q;
	assign drive_level = drive_level_q;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid)
		else $error("accepted request produced no result");

	a_old_state_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> old_state == $past(state_q))
		else $error("old_state does not match prior node state");

	a_new_state_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (new_state == state_q && drive_level == drive_q))
		else $error("result disagrees with stored node state");

	a_drive_rise_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_q) |-> $past(state_q) == ST_STARTING)
		else $error("drive raised outside starting");

	a_sensor_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && req_type == REQ_CHECK && !is_contactor_q)
		|=> (new_state == ST_ON || new_state == ST_OFF))
		else $error("sensor node left on/off on check");

endmodule
`default_nettype wire
